[sv/mse_pkg.sv]
// Shared types, opcodes and the helper function of the instruction executor.
package mse_pkg;

  localparam int DATA_WORDS_DEFAULT = 256;

  localparam logic CFG_START_PC  = 1'b0;
  localparam logic CFG_STACK_PTR = 1'b1;

  localparam logic [4:0] REG_SP = 5'd29;
  localparam logic [4:0] REG_RA = 5'd31;

  localparam logic [5:0] OP_RTYPE = 6'h00;
  localparam logic [5:0] OP_J     = 6'h02;
  localparam logic [5:0] OP_JAL   = 6'h03;
  localparam logic [5:0] OP_BEQ   = 6'h04;
  localparam logic [5:0] OP_BNE   = 6'h05;
  localparam logic [5:0] OP_BGTZ  = 6'h07;
  localparam logic [5:0] OP_ADDI  = 6'h08;
  localparam logic [5:0] OP_SLTI  = 6'h0A;
  localparam logic [5:0] OP_ANDI  = 6'h0C;
  localparam logic [5:0] OP_ORI   = 6'h0D;
  localparam logic [5:0] OP_NORI  = 6'h0E;
  localparam logic [5:0] OP_LUI   = 6'h0F;
  localparam logic [5:0] OP_LB    = 6'h20;
  localparam logic [5:0] OP_LH    = 6'h21;
  localparam logic [5:0] OP_LW    = 6'h23;
  localparam logic [5:0] OP_LBU   = 6'h24;
  localparam logic [5:0] OP_LHU   = 6'h25;
  localparam logic [5:0] OP_SB    = 6'h28;
  localparam logic [5:0] OP_SH    = 6'h29;
  localparam logic [5:0] OP_SW    = 6'h2B;
  localparam logic [5:0] OP_HALT  = 6'h3F;

  localparam logic [5:0] FN_SLL  = 6'h00;
  localparam logic [5:0] FN_SRL  = 6'h02;
  localparam logic [5:0] FN_SRA  = 6'h03;
  localparam logic [5:0] FN_JR   = 6'h08;
  localparam logic [5:0] FN_ADD  = 6'h20;
  localparam logic [5:0] FN_ADDU = 6'h21;
  localparam logic [5:0] FN_SUB  = 6'h22;
  localparam logic [5:0] FN_AND  = 6'h24;
  localparam logic [5:0] FN_OR   = 6'h25;
  localparam logic [5:0] FN_XOR  = 6'h26;
  localparam logic [5:0] FN_NOR  = 6'h27;
  localparam logic [5:0] FN_NAND = 6'h28;
  localparam logic [5:0] FN_SLT  = 6'h2A;

  typedef struct packed {
    logic        mode;
    logic [31:0] instruction;
    logic [7:0]  preload_index;
    logic [31:0] preload_word;
  } in_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic        reg_written;
    logic [4:0]  reg_index;
    logic [31:0] reg_value;
    logic        write_zero_error;
    logic        number_overflow;
    logic        address_overflow;
    logic        misaligned;
    logic        halted;
  } out_t;

  typedef struct packed {
    logic [31:0] npc;
    logic        halted;
    logic        wr;
    logic [4:0]  wr_idx;
    logic [31:0] wr_val;
    logic        pre;
    logic        ld;
    logic        st;
    logic [5:0]  op;
    logic [1:0]  low;
    logic [31:0] sdata;
    logic        no;
    logic        ao;
    logic        mis;
  } exec_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

[sv/mse_regfile.sv]
// Register file memory with two registered read ports, valid bits and write-first bypass.
module mse_regfile (
  input  logic        clk,
  input  logic        rst,
  input  logic        rd_en,
  input  logic [4:0]  rd_idx_a,
  input  logic [4:0]  rd_idx_b,
  output logic [31:0] q_a,
  output logic [31:0] q_b,
  input  logic        wr_en,
  input  logic [4:0]  wr_idx,
  input  logic [31:0] wr_data
);
  logic [31:0] mem [32];
  logic [31:0] valid;
  logic [31:0] qm_a;
  logic [31:0] qm_b;
  logic        zero_a;
  logic        zero_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en) begin
      valid[wr_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && wr_idx == rd_idx_a) begin
        qm_a   <= wr_data;
        zero_a <= 1'b0;
      end else begin
        qm_a   <= mem[rd_idx_a];
        zero_a <= !valid[rd_idx_a];
      end
      if (wr_en && wr_idx == rd_idx_b) begin
        qm_b   <= wr_data;
        zero_b <= 1'b0;
      end else begin
        qm_b   <= mem[rd_idx_b];
        zero_b <= !valid[rd_idx_b];
      end
    end
  end

  assign q_a = zero_a ? 32'd0 : qm_a;
  assign q_b = zero_b ? 32'd0 : qm_b;
endmodule

[sv/mse_dmem.sv]
// Data memory with one registered read port, write-first bypass and a clearing pass after reset.
module mse_dmem #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          rd_en,
  input  logic [$clog2(DATA_WORDS)-1:0] rd_idx,
  output logic [31:0]                   q,
  input  logic                          wr_en,
  input  logic [$clog2(DATA_WORDS)-1:0] wr_idx,
  input  logic [31:0]                   wr_data,
  output logic                          busy
);
  localparam int AW = $clog2(DATA_WORDS);

  logic [31:0]   mem [DATA_WORDS];
  logic [AW-1:0] clr_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b1;
      clr_idx <= '0;
    end else if (busy) begin
      if (clr_idx == AW'(DATA_WORDS - 1)) begin
        busy <= 1'b0;
      end else begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_idx] <= '0;
    end else if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
    if (rd_en) begin
      if (wr_en && wr_idx == rd_idx) begin
        q <= wr_data;
      end else begin
        q <= mem[rd_idx];
      end
    end
  end
endmodule

[sv/mse_exec.sv]
// Decode and execute stage: ALU, branch and jump targets, address checks and preload.
module mse_exec #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEFAULT
) (
  input  mse_pkg::in_t                  item,
  input  logic [31:0]                   a,
  input  logic [31:0]                   b,
  input  logic [31:0]                   pc,
  input  logic                          halt,
  output mse_pkg::exec_t                res,
  output logic [$clog2(DATA_WORDS)-1:0] mem_idx
);
  import mse_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);
  localparam logic [33:0] ADDR_LIMIT = 34'(DATA_WORDS * 4 - 1);

  logic [5:0]  op;
  logic [5:0]  fn;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sh;
  logic [15:0] imm;
  logic [31:0] simm;
  logic [31:0] pc4;
  logic [31:0] sum;
  logic [31:0] dif;
  logic [31:0] isum;
  logic [33:0] addr;
  logic        take;
  logic        word;
  logic        half;
  logic [31:0] pl_idx;

  assign op   = item.instruction[31:26];
  assign rt   = item.instruction[20:16];
  assign rd   = item.instruction[15:11];
  assign sh   = item.instruction[10:6];
  assign fn   = item.instruction[5:0];
  assign imm  = item.instruction[15:0];
  assign simm = sext16(imm);
  assign pc4  = pc + 32'd4;
  assign sum  = a + b;
  assign dif  = a - b;
  assign isum = a + simm;
  assign addr = {{2{a[31]}}, a} + {{2{simm[31]}}, simm};
  assign word = (op == OP_LW) || (op == OP_SW);
  assign half = (op == OP_LH) || (op == OP_LHU) || (op == OP_SH);
  assign pl_idx = 32'(item.preload_index);

  always_comb begin
    res        = '0;
    res.npc    = pc;
    res.halted = halt;
    res.op     = op;
    res.low    = addr[1:0];
    res.sdata  = b;
    mem_idx    = addr[AW+1:2];
    take       = 1'b0;
    if (item.mode) begin
      res.pre   = pl_idx < 32'(DATA_WORDS);
      res.sdata = item.preload_word;
      mem_idx   = pl_idx[AW-1:0];
    end else if (halt) begin
      res.npc = pc;
    end else if (op == OP_HALT) begin
      res.halted = 1'b1;
    end else begin
      res.npc = pc4;
      unique case (op)
        OP_RTYPE: begin
          res.wr_idx = rd;
          unique case (fn)
            FN_ADD, FN_ADDU: begin
              res.wr     = 1'b1;
              res.wr_val = sum;
              res.no     = (fn == FN_ADD) && ((a[31] ^ sum[31]) & (b[31] ^ sum[31]));
            end
            FN_SUB: begin
              res.wr     = 1'b1;
              res.wr_val = dif;
              res.no     = (a[31] ^ b[31]) & (a[31] ^ dif[31]);
            end
            FN_AND:  begin res.wr = 1'b1; res.wr_val = a & b; end
            FN_OR:   begin res.wr = 1'b1; res.wr_val = a | b; end
            FN_XOR:  begin res.wr = 1'b1; res.wr_val = a ^ b; end
            FN_NOR:  begin res.wr = 1'b1; res.wr_val = ~(a | b); end
            FN_NAND: begin res.wr = 1'b1; res.wr_val = ~(a & b); end
            FN_SLT: begin
              res.wr     = 1'b1;
              res.wr_val = {31'd0, $signed(a) < $signed(b)};
            end
            FN_SLL: begin res.wr = 1'b1; res.wr_val = b << sh; end
            FN_SRL: begin res.wr = 1'b1; res.wr_val = b >> sh; end
            FN_SRA: begin res.wr = 1'b1; res.wr_val = 32'($signed(b) >>> sh); end
            FN_JR:   res.npc = a;
            default: res.wr = 1'b0;
          endcase
        end
        OP_J, OP_JAL: begin
          res.wr     = (op == OP_JAL);
          res.wr_idx = REG_RA;
          res.wr_val = pc4;
          res.npc    = {pc4[31:28], item.instruction[25:0], 2'b00};
        end
        OP_BEQ, OP_BNE, OP_BGTZ: begin
          if (op == OP_BEQ) begin
            take = (a == b);
          end else if (op == OP_BNE) begin
            take = (a != b);
          end else begin
            take = !a[31] && (a != 32'd0);
          end
          if (take) begin
            res.npc = pc4 + {simm[29:0], 2'b00};
          end
        end
        OP_ADDI: begin
          res.wr     = 1'b1;
          res.wr_idx = rt;
          res.wr_val = isum;
          res.no     = (a[31] ^ isum[31]) & (simm[31] ^ isum[31]);
        end
        OP_LUI:  begin res.wr = 1'b1; res.wr_idx = rt; res.wr_val = {imm, 16'd0}; end
        OP_ANDI: begin res.wr = 1'b1; res.wr_idx = rt; res.wr_val = a & {16'd0, imm}; end
        OP_ORI:  begin res.wr = 1'b1; res.wr_idx = rt; res.wr_val = a | {16'd0, imm}; end
        OP_NORI: begin res.wr = 1'b1; res.wr_idx = rt; res.wr_val = ~(a | {16'd0, imm}); end
        OP_SLTI: begin
          res.wr     = 1'b1;
          res.wr_idx = rt;
          res.wr_val = {31'd0, $signed(a) < $signed(simm)};
        end
        OP_LW, OP_LH, OP_LHU, OP_LB, OP_LBU, OP_SW, OP_SH, OP_SB: begin
          res.mis = (word && addr[1:0] != 2'b00) || (half && addr[0]);
          res.ao  = addr[33] || (addr > ADDR_LIMIT);
          res.wr_idx = rt;
          if (res.mis || res.ao) begin
            res.halted = 1'b1;
          end else if (op == OP_SW || op == OP_SH || op == OP_SB) begin
            res.st = 1'b1;
          end else begin
            res.ld = 1'b1;
            res.wr = 1'b1;
          end
        end
        default: res.wr = 1'b0;
      endcase
    end
  end
endmodule

[sv/mips_subset_instruction_executor_unit.sv]
// Top level of the instruction executor: three-stage pipeline around register and data memories.
// One transaction is accepted per clock unless the output stalls or the data memory is clearing;
// its result passes register read at the accepting edge, execute with data memory read, then
// write-back into the output register. The rate of one per clock is held by forwarding from
// write-back to execute and by write-first bypass in both memories. After reset a clearing
// pass zeroes the data memory, during which no input transaction is accepted; configuration
// writes are taken at any time and must only be issued while no transaction is in flight.
module mips_subset_instruction_executor_unit #(
  parameter int DATA_WORDS = mse_pkg::DATA_WORDS_DEFAULT
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mse_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output mse_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [31:0]   cfg_data
);
  import mse_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);

  logic          adv;
  logic          busy;
  logic          s1v;
  in_t           s1;
  logic [31:0]   qa;
  logic [31:0]   qb;
  logic [31:0]   a;
  logic [31:0]   b;
  logic [31:0]   pc;
  logic          halt;
  exec_t         ex;
  logic [AW-1:0] ex_idx;
  logic          s2v;
  exec_t         s2;
  logic [AW-1:0] s2_idx;
  logic [31:0]   w;
  logic [31:0]   val;
  logic [31:0]   st_word;
  logic [4:0]    bsh;
  logic [4:0]    hsh;
  logic [7:0]    byt;
  logic [15:0]   hw;
  logic          wb_reg;
  logic          wb_zero;
  logic          rf_we;
  logic [4:0]    rf_widx;
  logic [31:0]   rf_wdata;
  logic          dm_we;

  assign adv       = !out_valid || out_ready;
  assign in_ready  = adv && !busy;
  assign cfg_ready = 1'b1;

  assign rf_we    = (adv && wb_reg) || (cfg_valid && cfg_index == CFG_STACK_PTR);
  assign rf_widx  = (adv && wb_reg) ? s2.wr_idx : REG_SP;
  assign rf_wdata = (adv && wb_reg) ? val : cfg_data;

  mse_regfile u_rf (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (adv),
    .rd_idx_a (in_data.instruction[25:21]),
    .rd_idx_b (in_data.instruction[20:16]),
    .q_a      (qa),
    .q_b      (qb),
    .wr_en    (rf_we),
    .wr_idx   (rf_widx),
    .wr_data  (rf_wdata)
  );

  assign a = (wb_reg && s2.wr_idx == s1.instruction[25:21]) ? val : qa;
  assign b = (wb_reg && s2.wr_idx == s1.instruction[20:16]) ? val : qb;

  mse_exec #(.DATA_WORDS(DATA_WORDS)) u_ex (
    .item    (s1),
    .a       (a),
    .b       (b),
    .pc      (pc),
    .halt    (halt),
    .res     (ex),
    .mem_idx (ex_idx)
  );

  assign dm_we = adv && s2v && (s2.pre || s2.st);

  mse_dmem #(.DATA_WORDS(DATA_WORDS)) u_dm (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (adv),
    .rd_idx  (ex_idx),
    .q       (w),
    .wr_en   (dm_we),
    .wr_idx  (s2_idx),
    .wr_data (st_word),
    .busy    (busy)
  );

  always_comb begin
    bsh = {~s2.low, 3'b000};
    hsh = (s2.low == 2'b10) ? 5'd0 : 5'd16;
    byt = 8'(w >> bsh);
    hw  = 16'(w >> hsh);
    val = s2.wr_val;
    if (s2.ld) begin
      unique case (s2.op)
        OP_LW:   val = w;
        OP_LH:   val = sext16(hw);
        OP_LHU:  val = {16'd0, hw};
        OP_LB:   val = {{24{byt[7]}}, byt};
        default: val = {24'd0, byt};
      endcase
    end
    if (s2.pre || s2.op == OP_SW) begin
      st_word = s2.sdata;
    end else if (s2.op == OP_SH) begin
      st_word = (w & ~(32'h0000ffff << hsh)) | ({16'd0, s2.sdata[15:0]} << hsh);
    end else begin
      st_word = (w & ~(32'h000000ff << bsh)) | ({24'd0, s2.sdata[7:0]} << bsh);
    end
  end

  assign wb_reg  = s2v && s2.wr && (s2.wr_idx != 5'd0);
  assign wb_zero = s2v && s2.wr && (s2.wr_idx == 5'd0) && (val != 32'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v       <= 1'b0;
      s2v       <= 1'b0;
      out_valid <= 1'b0;
      pc        <= '0;
      halt      <= 1'b0;
    end else begin
      if (adv) begin
        s1v       <= in_valid && in_ready;
        s2v       <= s1v;
        out_valid <= s2v;
      end
      if (adv && s1v) begin
        pc   <= ex.npc;
        halt <= ex.halted;
      end else if (cfg_valid && cfg_index == CFG_START_PC) begin
        pc <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1     <= in_data;
      s2     <= ex;
      s2_idx <= ex_idx;
      if (s2v) begin
        out_data.next_pc          <= s2.npc;
        out_data.reg_written      <= wb_reg;
        out_data.reg_index        <= wb_reg ? s2.wr_idx : 5'd0;
        out_data.reg_value        <= wb_reg ? val : 32'd0;
        out_data.write_zero_error <= wb_zero;
        out_data.number_overflow  <= s2.no;
        out_data.address_overflow <= s2.ao;
        out_data.misaligned       <= s2.mis;
        out_data.halted           <= s2.halted;
      end
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    !(in_valid && in_ready && busy))
    else $error("input transaction accepted during data memory clear");

  a_pc_hold_stall: assert property (@(posedge clk) disable iff (rst)
    (s1v && !adv && !cfg_valid) |=> $stable(pc))
    else $error("program counter moved while the pipeline was stalled");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_data.misaligned || out_data.address_overflow)) |-> out_data.halted)
    else $error("memory fault without halt");

  a_no_r0_write: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.reg_written) |-> (out_data.reg_index != 5'd0))
    else $error("register zero reported as written");

  a_no_store_on_fault: assert property (@(posedge clk) disable iff (rst)
    (s2v && (s2.mis || s2.ao)) |-> !(s2.st || s2.ld))
    else $error("memory access issued despite fault");
endmodule
